// File: rtl/multi_waveform_oscillator_defines.svh
// assertion macros shared by the oscillator rtl
// expects clk and rst_n in the scope of each use
`ifndef MULTI_WAVEFORM_OSCILLATOR_DEFINES_SVH
`define MULTI_WAVEFORM_OSCILLATOR_DEFINES_SVH

// same-cycle implication
`define MWO_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("oscillator check failed");

// next-cycle implication
`define MWO_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("oscillator check failed");

`endif

// File: rtl/mwo_pkg.sv
// shared types, constants and the quarter-wave sine rom contents
// no dependencies
package mwo_pkg;

  localparam int SINE_TABLE_BITS = 10;
  localparam int PHASE_BITS      = 32;
  localparam int QUARTER_LEN     = 1 << SINE_TABLE_BITS;
  localparam int ROM_ADDR_W      = SINE_TABLE_BITS + 1;
  localparam int SAMPLE_W        = 16;
  localparam int MAG_W           = SAMPLE_W - 1;
  localparam int STEP_W          = 32;
  localparam int CFG_INDEX_W     = 2;
  localparam int CFG_DATA_W      = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_WAVE_SELECT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PLAYING     = 2'd2;

  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_SQUARE = 2'd1,
    WAVE_SAW    = 2'd2,
    WAVE_TRI    = 2'd3
  } wave_t;

  typedef struct packed {
    wave_t             wave_select;
    logic [STEP_W-1:0] phase_step;
    logic              playing;
  } cfg_t;

  // first stage result handed to the waveform shaper
  typedef struct packed {
    logic              playing;
    wave_t             wave;
    logic [15:0]       u;
    logic              sine_neg;
    logic [MAG_W-1:0]  sine_mag;
    logic              last;
  } s1_t;

  typedef logic [MAG_W-1:0] sine_rom_t [0:QUARTER_LEN];

  // q30 taylor series to order 13, rounded to q15
  function automatic logic [MAG_W-1:0] quarter_entry(int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    x  = (HALF_PI_Q30 * 64'(k)) / 64'(QUARTER_LEN);
    x2 = (x * x) >> 30;
    t  = Q30_ONE - x2 / 64'd156;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    s  = (s + 64'd16384) >> 15;
    if (s > 64'd32767) s = 64'd32767;
    return s[MAG_W-1:0];
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int unsigned k = 0; k <= QUARTER_LEN; k++) begin
      rom[ROM_ADDR_W'(k)] = quarter_entry(k);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// File: rtl/mwo_if.sv
// valid/ready stream interfaces for tick beats in and sample beats out
// uses mwo_pkg
interface mwo_in_if;
  logic valid;
  logic ready;
  logic last_tick;
  modport source (output valid, output last_tick, input ready);
  modport sink   (input valid, input last_tick, output ready);
endinterface

interface mwo_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [mwo_pkg::SAMPLE_W-1:0] sample;
  logic                                last_out;
  modport source (output valid, output sample, output last_out, input ready);
  modport sink   (input valid, input sample, input last_out, output ready);
endinterface

// File: rtl/multi_waveform_oscillator.sv
// multi-waveform dds oscillator: one tick beat in, one q1.15 sample beat out
// a tick accept reaches sample valid through the phase/rom register, then the output register
// throughput 1 sample per cycle; the two-stage pipeline stalls only on out_beat.ready
// synchronous active-low reset clears phase, config registers and pipeline valids
// uses mwo_pkg, mwo_if, mwo_phase and mwo_shape
module multi_waveform_oscillator (
  input  logic                               clk,
  input  logic                               rst_n,
  mwo_in_if.sink                             in_beat,
  mwo_out_if.source                          out_beat,
  input  logic                               cfg_we,
  input  logic [mwo_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mwo_pkg::CFG_DATA_W-1:0]     cfg_data
);

  mwo_pkg::cfg_t cfg_r;
  logic          s1_valid;
  logic          s1_take;
  mwo_pkg::s1_t  s1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wave_select <= mwo_pkg::WAVE_SINE;
      cfg_r.phase_step  <= '0;
      cfg_r.playing     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        mwo_pkg::REG_WAVE_SELECT: cfg_r.wave_select <= mwo_pkg::wave_t'(cfg_data[1:0]);
        mwo_pkg::REG_PHASE_STEP:  cfg_r.phase_step  <= cfg_data[mwo_pkg::STEP_W-1:0];
        mwo_pkg::REG_PLAYING:     cfg_r.playing     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  mwo_phase u_phase (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_beat  (in_beat),
    .cfg      (cfg_r),
    .s1_take  (s1_take),
    .s1_valid (s1_valid),
    .s1       (s1)
  );

  mwo_shape u_shape (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1       (s1),
    .s1_take  (s1_take),
    .out_beat (out_beat)
  );

endmodule

// File: rtl/mwo_phase.sv
// phase accumulator, sine rom lookup and first pipeline register
// uses mwo_pkg, mwo_in_if and the assertion macros
`include "multi_waveform_oscillator_defines.svh"

module mwo_phase (
  input  logic                  clk,
  input  logic                  rst_n,
  mwo_in_if.sink                in_beat,
  input  mwo_pkg::cfg_t         cfg,
  input  logic                  s1_take,
  output logic                  s1_valid,
  output mwo_pkg::s1_t          s1
);

  logic [mwo_pkg::PHASE_BITS-1:0]      phase_acc_r;
  logic [mwo_pkg::PHASE_BITS-1:0]      phase_nxt;
  logic                                s1_valid_r;
  mwo_pkg::s1_t                        s1_r;
  logic [mwo_pkg::MAG_W-1:0]           rom_q_r;
  logic [1:0]                          quad;
  logic [mwo_pkg::SINE_TABLE_BITS-1:0] idx;
  logic [mwo_pkg::ROM_ADDR_W-1:0]      rom_addr;
  logic                                fire;

  assign in_beat.ready = !s1_valid_r || s1_take;
  assign fire          = in_beat.valid && in_beat.ready;
  assign phase_nxt     = phase_acc_r + mwo_pkg::PHASE_BITS'(cfg.phase_step);

  assign quad = phase_acc_r[mwo_pkg::PHASE_BITS-1 -: 2];
  assign idx  = phase_acc_r[mwo_pkg::PHASE_BITS-3 -: mwo_pkg::SINE_TABLE_BITS];

  // odd quadrants read the table mirrored
  always_comb begin
    if (quad[0]) begin
      rom_addr = mwo_pkg::ROM_ADDR_W'(mwo_pkg::QUARTER_LEN) - {1'b0, idx};
    end else begin
      rom_addr = {1'b0, idx};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_acc_r <= '0;
      s1_valid_r  <= 1'b0;
    end else begin
      if (fire) begin
        s1_valid_r <= 1'b1;
        if (cfg.playing) phase_acc_r <= phase_nxt;
      end else if (s1_take) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rom_q_r       <= mwo_pkg::SINE_ROM[rom_addr];
      s1_r.playing  <= cfg.playing;
      s1_r.wave     <= cfg.wave_select;
      s1_r.u        <= phase_acc_r[mwo_pkg::PHASE_BITS-1 -: 16];
      s1_r.sine_neg <= quad[1];
      s1_r.sine_mag <= '0;
      s1_r.last     <= in_beat.last_tick;
    end
  end

  assign s1_valid = s1_valid_r;

  always_comb begin
    s1          = s1_r;
    s1.sine_mag = rom_q_r;
  end

  `MWO_ASSERT_NEXT(a_phase_hold, fire && !cfg.playing, phase_acc_r == $past(phase_acc_r))
  `MWO_ASSERT_NEXT(a_phase_step, fire && cfg.playing, phase_acc_r == $past(phase_nxt))
  `MWO_ASSERT_NOW(a_rom_addr, 1'b1, rom_addr <= mwo_pkg::ROM_ADDR_W'(mwo_pkg::QUARTER_LEN))

endmodule

// File: rtl/mwo_shape.sv
// waveform shaping from the registered phase and the output register
// uses mwo_pkg and mwo_out_if
module mwo_shape (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          s1_valid,
  input  mwo_pkg::s1_t  s1,
  output logic          s1_take,
  mwo_out_if.source     out_beat
);

  logic                                out_valid_r;
  logic signed [mwo_pkg::SAMPLE_W-1:0] sample_r;
  logic signed [mwo_pkg::SAMPLE_W-1:0] sample_nxt;
  logic                                last_r;
  logic signed [17:0]                  tri_val;
  logic signed [17:0]                  u_x2;

  assign s1_take = s1_valid && (!out_valid_r || out_beat.ready);
  assign u_x2    = {1'b0, s1.u, 1'b0};

  // triangle: rising, falling (peak saturates), rising again
  always_comb begin
    if (s1.u < 16'd16384) begin
      tri_val = u_x2;
    end else if (s1.u < 16'd49152) begin
      tri_val = 18'sd65536 - u_x2;
      if (tri_val > 18'sd32767) tri_val = 18'sd32767;
    end else begin
      tri_val = u_x2 - 18'sd131072;
    end
  end

  always_comb begin
    case (s1.wave)
      mwo_pkg::WAVE_SINE: begin
        if (s1.sine_neg) sample_nxt = -$signed({1'b0, s1.sine_mag});
        else             sample_nxt = $signed({1'b0, s1.sine_mag});
      end
      mwo_pkg::WAVE_SQUARE: sample_nxt = s1.u[15] ? 16'sh8000 : 16'sh7fff;
      mwo_pkg::WAVE_SAW:    sample_nxt = $signed({~s1.u[15], s1.u[14:0]});
      mwo_pkg::WAVE_TRI:    sample_nxt = tri_val[mwo_pkg::SAMPLE_W-1:0];
      default:              sample_nxt = '0;
    endcase
    if (!s1.playing) sample_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (s1_take)             out_valid_r <= 1'b1;
      else if (out_beat.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      sample_r <= sample_nxt;
      last_r   <= s1.last;
    end
  end

  assign out_beat.valid    = out_valid_r;
  assign out_beat.sample   = sample_r;
  assign out_beat.last_out = last_r;

endmodule

// File: verif/mwo_sample_checker.sv
`timescale 1ns / 1ps
// sample predictor and scoreboard for the multi-waveform oscillator
// watches the tick, sample and register ports; depends on mwo_pkg and mwo_if
module mwo_sample_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  mwo_in_if                               in_mon,
  mwo_out_if                              out_mon,
  input  logic                            cfg_we,
  input  logic [mwo_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mwo_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              fail_count,
  output int                              outstanding,
  output int                              samples_checked
);

  localparam int TABLE_BITS = 10;
  localparam int TABLE_SIZE = 1 << TABLE_BITS;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;
  localparam longint unsigned HALF_PI = 64'd1686629713;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
  } sample_beat_t;

  logic [14:0]  quarter_sine [0:TABLE_SIZE];
  sample_beat_t samples_due [$];

  mwo_pkg::wave_t cur_wave;
  logic [31:0]    cur_step;
  logic           cur_playing;
  logic [31:0]    phase_acc;
  int             fails;
  int             checked;

  // quarter-wave sine in q15 from a q30 taylor series, truncating divides
  initial begin
    longint unsigned x, x2, t, s;
    for (int k = 0; k <= TABLE_SIZE; k++) begin
      x  = (HALF_PI * longint'(k)) / TABLE_SIZE;
      x2 = (x * x) >> 30;
      t  = ONE_Q30 - x2 / 156;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 110;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 72;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
      s  = (x * t) >> 30;
      s  = (s + 64'd16384) >> 15;
      if (s > 64'd32767) s = 64'd32767;
      quarter_sine[(TABLE_BITS + 1)'(k)] = s[14:0];
    end
  end

  function automatic logic signed [15:0] shape_sample(mwo_pkg::wave_t wave,
                                                      logic [31:0] phase);
    logic [15:0]           u;
    logic [TABLE_BITS+1:0] top;
    logic [TABLE_BITS:0]   addr;
    logic [14:0]           mag;
    int                    s;
    u   = phase[31:16];
    top = phase[31 -: TABLE_BITS + 2];
    case (wave)
      mwo_pkg::WAVE_SQUARE: s = u[15] ? -32768 : 32767;
      mwo_pkg::WAVE_SAW:    s = int'(u) - 32768;
      mwo_pkg::WAVE_TRI: begin
        if (u < 16'd16384) s = 2 * int'(u);
        else if (u < 16'd49152) s = 65536 - 2 * int'(u);
        else s = 2 * int'(u) - 131072;
        if (s > 32767) s = 32767;
      end
      default: begin
        // odd quadrants run the table backwards, upper half is negated
        if (top[TABLE_BITS]) begin
          addr = (TABLE_BITS + 1)'(TABLE_SIZE) - {1'b0, top[TABLE_BITS-1:0]};
        end else begin
          addr = {1'b0, top[TABLE_BITS-1:0]};
        end
        mag = quarter_sine[addr];
        s = top[TABLE_BITS+1] ? -int'(mag) : int'(mag);
      end
    endcase
    return 16'(s);
  endfunction

  always @(posedge clk) begin
    sample_beat_t want;
    if (!rst_n) begin
      samples_due.delete();
      cur_wave    = mwo_pkg::WAVE_SINE;
      cur_step    = '0;
      cur_playing = 1'b0;
      phase_acc   = '0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (samples_due.size() == 0) begin
          $error("sample beat with nothing expected: sample %0d, last_out %0b",
                 out_mon.sample, out_mon.last_out);
          fails++;
        end else begin
          want = samples_due.pop_front();
          if (out_mon.sample !== want.sample) begin
            $error("sample mismatch: expected %0d, actual %0d", want.sample, out_mon.sample);
            fails++;
          end
          if (out_mon.last_out !== want.last) begin
            $error("last_out mismatch: expected %0b, actual %0b", want.last, out_mon.last_out);
            fails++;
          end
          checked++;
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        want.sample = cur_playing ? shape_sample(cur_wave, phase_acc) : '0;
        want.last   = in_mon.last_tick;
        // paused playback holds the phase
        if (cur_playing) phase_acc = phase_acc + cur_step;
        samples_due.push_back(want);
      end
      if (cfg_we) begin
        case (cfg_index)
          mwo_pkg::REG_WAVE_SELECT: cur_wave = mwo_pkg::wave_t'(cfg_data[1:0]);
          mwo_pkg::REG_PHASE_STEP:  cur_step = cfg_data[31:0];
          mwo_pkg::REG_PLAYING:     cur_playing = cfg_data[0];
          default: ;
        endcase
      end
    end
    fail_count      <= fails;
    outstanding     <= samples_due.size();
    samples_checked <= checked;
  end

endmodule

// File: verif/multi_waveform_oscillator_tb.sv
`timescale 1ns / 1ps
// tick stimulus, register programming and verdict for the multi-waveform oscillator
// depends on mwo_pkg, mwo_if, multi_waveform_oscillator and mwo_sample_checker
module multi_waveform_oscillator_tb;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_TICKS = 500;
  localparam int TAIL_CYCLES  = 6;
  localparam logic [mwo_pkg::CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [mwo_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [mwo_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  bit                              gaps_on = 1'b1;
  int                              cycles;
  int                              ticks_sent;
  int                              settings_used;
  int                              fail_count;
  int                              outstanding;
  int                              samples_checked;

  mwo_in_if  in_ch ();
  mwo_out_if out_ch ();

  multi_waveform_oscillator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_beat   (in_ch),
    .out_beat  (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mwo_sample_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .samples_checked (samples_checked)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("no progress after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // sample sink with random stall bursts
  initial begin
    int stall;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall == 0 && gaps_on && $urandom_range(0, 4) == 0) stall = $urandom_range(1, 5);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // unused bits of the narrow registers carry noise to check masking
  task automatic program_osc(input mwo_pkg::wave_t wave, input logic [31:0] step,
                             input logic play);
    cfg_we    <= 1'b1;
    cfg_index <= mwo_pkg::REG_WAVE_SELECT;
    cfg_data  <= ($urandom() & 32'hFFFF_FFFC) | 32'(wave);
    @(posedge clk);
    cfg_index <= mwo_pkg::REG_PHASE_STEP;
    cfg_data  <= step;
    @(posedge clk);
    cfg_index <= mwo_pkg::REG_PLAYING;
    cfg_data  <= ($urandom() & 32'hFFFF_FFFE) | 32'(play);
    @(posedge clk);
    cfg_index <= REG_SPARE;
    cfg_data  <= $urandom();
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic send_tick(input logic last);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.last_tick <= last;
    do @(posedge clk); while (!in_ch.ready);
    ticks_sent++;
  endtask

  // hold off ticks until every sample beat has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    logic [31:0] step;
    int          goal;
    in_ch.valid     = 1'b0;
    in_ch.last_tick = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset state: not playing, zero samples
    send_tick(1'b0);
    send_tick(1'b1);
    drain();
    // quarter- and half-period steps land on the waveform corners
    program_osc(mwo_pkg::WAVE_SAW, 32'h4000_0000, 1'b1);
    repeat (4) send_tick(1'($urandom_range(0, 1)));
    drain();
    program_osc(mwo_pkg::WAVE_TRI, 32'h4000_0000, 1'b1);
    repeat (4) send_tick(1'($urandom_range(0, 1)));
    drain();
    program_osc(mwo_pkg::WAVE_SQUARE, 32'h8000_0000, 1'b1);
    repeat (2) send_tick(1'($urandom_range(0, 1)));
    drain();
    program_osc(mwo_pkg::WAVE_SINE, 32'h4000_0000, 1'b1);
    repeat (4) send_tick(1'($urandom_range(0, 1)));
    drain();
    // largest step wraps to the top of the phase range
    program_osc(mwo_pkg::WAVE_SAW, 32'hFFFF_FFFF, 1'b1);
    repeat (2) send_tick(1'($urandom_range(0, 1)));
    drain();
    program_osc(mwo_pkg::WAVE_SINE, 32'hFFFF_FFFF, 1'b1);
    repeat (2) send_tick(1'($urandom_range(0, 1)));
    drain();
    program_osc(mwo_pkg::WAVE_TRI, 32'h0000_0000, 1'b1);
    repeat (2) send_tick(1'($urandom_range(0, 1)));
    drain();
    program_osc(mwo_pkg::WAVE_SQUARE, 32'h1234_5678, 1'b0);
    repeat (2) send_tick(1'($urandom_range(0, 1)));
    drain();

    goal = ticks_sent + RANDOM_TICKS;
    while (ticks_sent < goal) begin
      gaps_on = (goal - ticks_sent > 80) && ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 5))
        0:       step = 32'h0000_0000;
        1:       step = 32'hFFFF_FFFF;
        2:       step = $urandom_range(1, 1 << 20);
        3:       step = $urandom_range(1 << 24, 1 << 28);
        4:       step = 32'h8000_0000 - $urandom_range(0, 1 << 16);
        default: step = $urandom();
      endcase
      program_osc(mwo_pkg::wave_t'($urandom_range(0, 3)), step, $urandom_range(0, 9) != 0);
      repeat ($urandom_range(10, 60)) send_tick($urandom_range(0, 7) == 0);
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d ticks sent over %0d oscillator settings, %0d samples compared",
             ticks_sent, settings_used, samples_checked);
    $display("covered all waveforms, zero and full-range steps, paused playback, last flag");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/mwo_pkg.sv
rtl/mwo_if.sv
rtl/mwo_phase.sv
rtl/mwo_shape.sv
rtl/multi_waveform_oscillator.sv
verif/mwo_sample_checker.sv
verif/multi_waveform_oscillator_tb.sv
